### hw/rtl/qadd_pkg.sv
package qadd_pkg;

    // Configuration port geometry
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // Multiplier width: default and widest supported
    localparam int MULT_WIDTH_DEF = 22;
    localparam int MULT_MAX_W     = 32;

    // Accumulator and field widths
    localparam int ACC_W    = 32;
    localparam int SHIFT_W  = 5;
    localparam int THRESH_W = 30;
    localparam int BYTE_W   = 8;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_A     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_B     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BIAS_TERM   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_SHIFT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROUND_THRESH = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_OFFSET  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_LOW   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_HIGH  = 3'd7;

    // Reset value of the upper bound
    localparam logic [BYTE_W-1:0] CLAMP_HIGH_RST = 8'd255;

    // Input item
    typedef struct packed {
        logic [BYTE_W-1:0] value_a;
        logic [BYTE_W-1:0] value_b;
        logic              is_final;
    } in_t;

    // Result item
    typedef struct packed {
        logic [BYTE_W-1:0] sum_out;
        logic              final_out;
    } out_t;

    // Register file contents seen by the datapath (scales zero-extended)
    typedef struct packed {
        logic [MULT_MAX_W-1:0] scale_a;
        logic [MULT_MAX_W-1:0] scale_b;
        logic [ACC_W-1:0]      bias_term;
        logic [SHIFT_W-1:0]    right_shift;
        logic [THRESH_W-1:0]   round_threshold;
        logic [BYTE_W-1:0]     out_offset;
        logic [BYTE_W-1:0]     clamp_low;
        logic [BYTE_W-1:0]     clamp_high;
    } cfg_t;

    // Accumulated sum travelling from the MAC to the requantizer
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic             is_final;
    } acc_item_t;

endpackage

### hw/rtl/qadd_cfg.sv
module qadd_cfg #(
    parameter int MULT_WIDTH = qadd_pkg::MULT_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [qadd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [qadd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output qadd_pkg::cfg_t                     cfg
);

    logic [MULT_WIDTH-1:0]             scale_a_reg;
    logic [MULT_WIDTH-1:0]             scale_b_reg;
    logic [qadd_pkg::ACC_W-1:0]        bias_term_reg;
    logic [qadd_pkg::SHIFT_W-1:0]      right_shift_reg;
    logic [qadd_pkg::THRESH_W-1:0]     round_threshold_reg;
    logic [qadd_pkg::BYTE_W-1:0]       out_offset_reg;
    logic [qadd_pkg::BYTE_W-1:0]       clamp_low_reg;
    logic [qadd_pkg::BYTE_W-1:0]       clamp_high_reg;
    logic                              wr_en;

    // Always able to take a write
    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    // Register file, each write truncated to its register width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_a_reg         <= '0;
            scale_b_reg         <= '0;
            bias_term_reg       <= '0;
            right_shift_reg     <= '0;
            round_threshold_reg <= '0;
            out_offset_reg      <= '0;
            clamp_low_reg       <= '0;
            clamp_high_reg      <= qadd_pkg::CLAMP_HIGH_RST;
        end
        else if (wr_en)
        begin
            case (cfg_index)
                qadd_pkg::REG_SCALE_A:      scale_a_reg <= cfg_data[MULT_WIDTH-1:0];
                qadd_pkg::REG_SCALE_B:      scale_b_reg <= cfg_data[MULT_WIDTH-1:0];
                qadd_pkg::REG_BIAS_TERM:    bias_term_reg <= cfg_data[qadd_pkg::ACC_W-1:0];
                qadd_pkg::REG_RIGHT_SHIFT:  right_shift_reg <= cfg_data[qadd_pkg::SHIFT_W-1:0];
                qadd_pkg::REG_ROUND_THRESH:
                    round_threshold_reg <= cfg_data[qadd_pkg::THRESH_W-1:0];
                qadd_pkg::REG_OUT_OFFSET:   out_offset_reg <= cfg_data[qadd_pkg::BYTE_W-1:0];
                qadd_pkg::REG_CLAMP_LOW:    clamp_low_reg <= cfg_data[qadd_pkg::BYTE_W-1:0];
                qadd_pkg::REG_CLAMP_HIGH:   clamp_high_reg <= cfg_data[qadd_pkg::BYTE_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Present the registers to the datapath
    always_comb
    begin
        cfg.scale_a         = qadd_pkg::MULT_MAX_W'(scale_a_reg);
        cfg.scale_b         = qadd_pkg::MULT_MAX_W'(scale_b_reg);
        cfg.bias_term       = bias_term_reg;
        cfg.right_shift     = right_shift_reg;
        cfg.round_threshold = round_threshold_reg;
        cfg.out_offset      = out_offset_reg;
        cfg.clamp_low       = clamp_low_reg;
        cfg.clamp_high      = clamp_high_reg;
    end

endmodule

### hw/rtl/qadd_mac.sv
module qadd_mac #(
    parameter int MULT_WIDTH = qadd_pkg::MULT_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  qadd_pkg::cfg_t        cfg,
    input  logic                  up_valid,
    output logic                  up_stall,
    input  qadd_pkg::in_t         up_data,
    output logic                  dn_valid,
    input  logic                  dn_stall,
    output qadd_pkg::acc_item_t   dn_data
);

    localparam int PROD_W = MULT_WIDTH + qadd_pkg::BYTE_W;

    logic [PROD_W-1:0]          prod_a;
    logic [PROD_W-1:0]          prod_b;
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic                       s1_load;
    logic [qadd_pkg::ACC_W-1:0] prod_a_reg;
    logic [qadd_pkg::ACC_W-1:0] prod_b_reg;
    logic                       s1_final_reg;
    logic                       s2_valid_reg;
    logic                       s2_valid_next;
    logic                       s2_load;
    logic [qadd_pkg::ACC_W-1:0] acc_next;
    qadd_pkg::acc_item_t        s2_data_reg;

    // Stage loads when empty or when its content moves on
    assign s2_load  = !s2_valid_reg || !dn_stall;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign up_stall = !s1_load;

    // Stage 1: two byte-by-scale products
    assign prod_a = PROD_W'(up_data.value_a) * PROD_W'(cfg.scale_a[MULT_WIDTH-1:0]);
    assign prod_b = PROD_W'(up_data.value_b) * PROD_W'(cfg.scale_b[MULT_WIDTH-1:0]);
    assign s1_valid_next = s1_load ? up_valid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && up_valid)
        begin
            prod_a_reg   <= qadd_pkg::ACC_W'(prod_a);
            prod_b_reg   <= qadd_pkg::ACC_W'(prod_b);
            s1_final_reg <= up_data.is_final;
        end
    end

    // Stage 2: wrap-around sum with the bias term
    assign acc_next      = cfg.bias_term + prod_a_reg + prod_b_reg;
    assign s2_valid_next = s2_load ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            s2_data_reg.acc      <= acc_next;
            s2_data_reg.is_final <= s1_final_reg;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign dn_data  = s2_data_reg;

    // A held stage 1 item stays until stage 2 takes it
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_load) |=> s1_valid_reg)
        else $error("stage 1 item dropped while stage 2 was blocked");

    // Stage 2 only fills from a valid stage 1 item
    a_s2_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!s2_valid_reg && !s1_valid_reg) |=> !s2_valid_reg)
        else $error("stage 2 became valid without a stage 1 item");

    // A stalled item downstream holds still
    a_dn_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (dn_valid && dn_stall) |=> (dn_valid && $stable(dn_data)))
        else $error("stalled accumulator item changed");

endmodule

### hw/rtl/qadd_requant.sv
module qadd_requant (
    input  logic                  clk,
    input  logic                  rst_n,
    input  qadd_pkg::cfg_t        cfg,
    input  logic                  up_valid,
    output logic                  up_stall,
    input  qadd_pkg::acc_item_t   up_data,
    output logic                  dn_valid,
    input  logic                  dn_stall,
    output qadd_pkg::out_t        dn_data
);

    logic [qadd_pkg::ACC_W-1:0]        mask;
    logic signed [qadd_pkg::ACC_W-1:0] shifted;
    logic signed [qadd_pkg::ACC_W:0]   rem;
    logic                              round_up;
    logic                              s3_valid_reg;
    logic                              s3_valid_next;
    logic                              s3_load;
    logic signed [qadd_pkg::ACC_W-1:0] shifted_reg;
    logic                              round_up_reg;
    logic                              s3_final_reg;
    logic signed [qadd_pkg::ACC_W+1:0] biased;
    logic signed [qadd_pkg::ACC_W+1:0] lo_bound;
    logic signed [qadd_pkg::ACC_W+1:0] hi_bound;
    logic signed [qadd_pkg::ACC_W+1:0] after_low;
    logic signed [qadd_pkg::ACC_W+1:0] clamped;
    logic                              s4_valid_reg;
    logic                              s4_valid_next;
    logic                              s4_load;
    qadd_pkg::out_t                    s4_data_reg;

    // Stage loads when empty or when its content moves on
    assign s4_load  = !s4_valid_reg || !dn_stall;
    assign s3_load  = !s3_valid_reg || s4_load;
    assign up_stall = !s3_load;

    // Stage 3: arithmetic shift and rounding decision
    assign mask     = ~({qadd_pkg::ACC_W{1'b1}} << cfg.right_shift);
    assign shifted  = $signed(up_data.acc) >>> cfg.right_shift;
    assign rem      = $signed({1'b0, up_data.acc & mask})
                    - $signed({{qadd_pkg::ACC_W{1'b0}}, up_data.acc[qadd_pkg::ACC_W-1]});
    assign round_up = rem > $signed({3'b000, cfg.round_threshold});
    assign s3_valid_next = s3_load ? up_valid : s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_load && up_valid)
        begin
            shifted_reg  <= shifted;
            round_up_reg <= round_up;
            s3_final_reg <= up_data.is_final;
        end
    end

    // Stage 4: add the output zero point, apply low bound then high bound
    assign biased   = $signed({{2{shifted_reg[qadd_pkg::ACC_W-1]}}, shifted_reg})
                    + $signed({{(qadd_pkg::ACC_W+1){1'b0}}, round_up_reg})
                    + $signed({{(qadd_pkg::ACC_W+2-qadd_pkg::BYTE_W){1'b0}}, cfg.out_offset});
    assign lo_bound = $signed({{(qadd_pkg::ACC_W+2-qadd_pkg::BYTE_W){1'b0}}, cfg.clamp_low});
    assign hi_bound = $signed({{(qadd_pkg::ACC_W+2-qadd_pkg::BYTE_W){1'b0}}, cfg.clamp_high});

    always_comb
    begin
        after_low = (biased < lo_bound) ? lo_bound : biased;
        clamped   = (after_low > hi_bound) ? hi_bound : after_low;
    end

    assign s4_valid_next = s4_load ? s3_valid_reg : s4_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_load && s3_valid_reg)
        begin
            s4_data_reg.sum_out   <= clamped[qadd_pkg::BYTE_W-1:0];
            s4_data_reg.final_out <= s3_final_reg;
        end
    end

    assign dn_valid = s4_valid_reg;
    assign dn_data  = s4_data_reg;

    // The upper bound always wins
    a_clamp_high: assert property (@(posedge clk) disable iff (!rst_n)
        dn_valid |-> (dn_data.sum_out <= cfg.clamp_high))
        else $error("result above upper bound");

    // With ordered bounds the lower bound holds too
    a_clamp_low: assert property (@(posedge clk) disable iff (!rst_n)
        (dn_valid && (cfg.clamp_low <= cfg.clamp_high)) |-> (dn_data.sum_out >= cfg.clamp_low))
        else $error("result below lower bound");

    // No shift means no remainder to round on
    a_no_round_unshifted: assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && (cfg.right_shift == '0)) |-> !round_up)
        else $error("rounding increment with zero shift");

endmodule

### hw/rtl/quantized_add_requantize_u8_unit.sv
// Channel  Direction  Handshake                  Payload
// in       input      in_valid / in_stall        in_data   (qadd_pkg::in_t)
// out      output     out_valid / out_stall      out_data  (qadd_pkg::out_t)
// cfg      input      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One item per cycle while out is not stalled; an accepted item passes through the four
// pipeline registers in order: products, bias sum, shift/round, offset/clamp.
// rst_n clears the valid bits of all stages and loads the register reset values.
// A stall on out holds the output and backs up stage by stage; empty stages keep filling.
// cfg writes take effect at once and complete in the cycle they are offered.
module quantized_add_requantize_u8_unit #(
    parameter int MULT_WIDTH = qadd_pkg::MULT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  qadd_pkg::in_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output qadd_pkg::out_t                    out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qadd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [qadd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    qadd_pkg::cfg_t       cfg;
    logic                 acc_valid;
    logic                 acc_stall;
    qadd_pkg::acc_item_t  acc_data;

    // Configuration registers
    qadd_cfg #(
        .MULT_WIDTH (MULT_WIDTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Multiply and accumulate stages
    qadd_mac #(
        .MULT_WIDTH (MULT_WIDTH)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (in_valid),
        .up_stall (in_stall),
        .up_data  (in_data),
        .dn_valid (acc_valid),
        .dn_stall (acc_stall),
        .dn_data  (acc_data)
    );

    // Shift, round, offset and clamp stages
    qadd_requant u_requant (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (acc_valid),
        .up_stall (acc_stall),
        .up_data  (acc_data),
        .dn_valid (out_valid),
        .dn_stall (out_stall),
        .dn_data  (out_data)
    );

endmodule
